/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the elastic collision block.
// Files that check their own logic include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EDC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/edcol_pkg.sv */
// Package of the elastic collision block: widths, payload types, saturation.
// Used by edcol_div and elastic_disc_collision_2d_top; depends on nothing.
package edcol_pkg;

  // Field widths.
  localparam int unsigned VW    = 32;  // velocity and position, Q16.16
  localparam int unsigned MSW   = 16;  // mass, Q8.8
  localparam int unsigned DIFW  = 33;  // signed difference of two fields
  localparam int unsigned MAGW  = 32;  // magnitude of a difference
  localparam int unsigned PRW   = 64;  // product of two magnitudes
  localparam int unsigned DOTW  = 65;  // dot product magnitude, squared distance
  localparam int unsigned SUMW  = 17;  // mass sum
  localparam int unsigned BASEW = 81;  // dot product times one mass
  localparam int unsigned LOW   = 41;  // low slice of the base for the split multiply
  localparam int unsigned HIW   = BASEW - LOW;
  localparam int unsigned DENW  = 82;  // denominator
  localparam int unsigned NUMW  = 114; // numerator
  localparam int unsigned QW    = 36;  // quotient bits, one per divider stage
  localparam int unsigned RSW   = 38;  // velocity plus change before saturation

  // Divider lanes.
  localparam int unsigned NLANE   = 4;
  localparam int unsigned LANE_AX = 0;
  localparam int unsigned LANE_AY = 1;
  localparam int unsigned LANE_BX = 2;
  localparam int unsigned LANE_BY = 3;

  typedef logic [NUMW-1:0] num_t;
  typedef logic [DENW-1:0] den_t;
  typedef logic [QW-1:0]   quo_t;

  // Per-item sideband that rides along with the arithmetic.
  typedef struct packed {
    logic signed [VW-1:0] avx;
    logic signed [VW-1:0] avy;
    logic signed [VW-1:0] bvx;
    logic signed [VW-1:0] bvy;
    logic                 a_upd;
    logic                 b_upd;
    logic                 deg;
    logic                 neg_x;
    logic                 neg_y;
  } side_t;

  // First stage: differences as sign and magnitude.
  typedef struct packed {
    logic [MAGW-1:0]      drxm;
    logic [MAGW-1:0]      drym;
    logic [MAGW-1:0]      dvxm;
    logic [MAGW-1:0]      dvym;
    logic                 drx_neg;
    logic                 dry_neg;
    logic                 dvx_neg;
    logic                 dvy_neg;
    logic [MSW-1:0]       am;
    logic [MSW-1:0]       bm;
    logic [SUMW-1:0]      sum;
    logic                 a_stat;
    logic                 b_stat;
    logic signed [VW-1:0] avx;
    logic signed [VW-1:0] avy;
    logic signed [VW-1:0] bvx;
    logic signed [VW-1:0] bvy;
  } s1_t;

  // Second stage: the four magnitude products.
  typedef struct packed {
    logic [PRW-1:0]       p1;
    logic [PRW-1:0]       p2;
    logic [PRW-1:0]       dx2;
    logic [PRW-1:0]       dy2;
    logic                 s1;
    logic                 s2;
    logic                 drx_neg;
    logic                 dry_neg;
    logic [MAGW-1:0]      drxm;
    logic [MAGW-1:0]      drym;
    logic [MSW-1:0]       am;
    logic [MSW-1:0]       bm;
    logic [SUMW-1:0]      sum;
    logic                 a_upd;
    logic                 b_upd;
    logic                 deg;
    logic signed [VW-1:0] avx;
    logic signed [VW-1:0] avy;
    logic signed [VW-1:0] bvx;
    logic signed [VW-1:0] bvy;
  } s2_t;

  // Clamp a widened sum to the signed 32-bit range.
  function automatic logic signed [VW-1:0] sat_vel(input logic signed [RSW-1:0] v);
    logic signed [RSW-1:0] vmax;
    logic signed [RSW-1:0] vmin;
    vmax = RSW'({1'b0, {(VW-1){1'b1}}});
    vmin = -vmax - RSW'(1);
    if (v > vmax) begin
      return {1'b0, {(VW-1){1'b1}}};
    end else if (v < vmin) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else begin
      return v[VW-1:0];
    end
  endfunction

endpackage

/* rtl/edcol_div.sv */
// Pipelined restoring divider, four lanes sharing one denominator.
// One quotient bit per stage, QW stages; depends on edcol_pkg.
module edcol_div import edcol_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  num_t [NLANE-1:0]       num_i,
  input  den_t                   den_i,
  output quo_t [NLANE-1:0]       quo_o
);

  den_t den_q [QW];
  den_t rem_q [QW][NLANE];
  quo_t low_q [QW][NLANE];
  quo_t quo_q [QW][NLANE];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    den_t             den_p;
    den_t             rem_p [NLANE];
    quo_t             low_p [NLANE];
    quo_t             quo_p [NLANE];
    logic [DENW:0]    trial [NLANE];
    logic             ge    [NLANE];
    den_t             rem_d [NLANE];

    // Stage inputs: the operands for the first stage, the previous stage otherwise.
    if (k == 0) begin : g_first
      always_comb begin
        den_p = den_i;
        for (int l = 0; l < NLANE; l++) begin
          rem_p[l] = DENW'(num_i[l][NUMW-1:QW]);
          low_p[l] = num_i[l][QW-1:0];
          quo_p[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        den_p = den_q[k-1];
        for (int l = 0; l < NLANE; l++) begin
          rem_p[l] = rem_q[k-1][l];
          low_p[l] = low_q[k-1][l];
          quo_p[l] = quo_q[k-1][l];
        end
      end
    end

    // One compare and subtract per lane.
    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        trial[l] = {rem_p[l], low_p[l][QW-1]};
        ge[l]    = (trial[l] >= {1'b0, den_p});
        rem_d[l] = ge[l] ? DENW'(trial[l] - {1'b0, den_p}) : DENW'(trial[l]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_p;
        for (int l = 0; l < NLANE; l++) begin
          rem_q[k][l] <= rem_d[l];
          low_q[k][l] <= {low_p[l][QW-2:0], 1'b0};
          quo_q[k][l] <= {quo_p[l][QW-2:0], ge[l]};
        end
      end
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_out
    assign quo_o[l] = quo_q[QW-1][l];
  end

endmodule

/* rtl/elastic_disc_collision_2d_top.sv */
// Two-body elastic collision in 2D, Q16.16 velocities, fully pipelined.
// Input to result: 6 arithmetic stages, 36 divider stages, output register.
// Throughput: one pair per cycle while the output is not stalled; the 36-stage
// restoring divider and the split 81x32 multiply set the depth.
// A stalled output freezes the whole pipeline. Reset clears all valid bits
// and sets static_mass to zero. Depends on edcol_pkg, edcol_div, assert_macros.svh.
`include "assert_macros.svh"

module elastic_disc_collision_2d_top import edcol_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [MSW-1:0]          cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VW-1:0]    a_pos_x_i,
  input  logic signed [VW-1:0]    a_pos_y_i,
  input  logic signed [VW-1:0]    a_vel_x_i,
  input  logic signed [VW-1:0]    a_vel_y_i,
  input  logic [MSW-1:0]          a_mass_i,
  input  logic signed [VW-1:0]    b_pos_x_i,
  input  logic signed [VW-1:0]    b_pos_y_i,
  input  logic signed [VW-1:0]    b_vel_x_i,
  input  logic signed [VW-1:0]    b_vel_y_i,
  input  logic [MSW-1:0]          b_mass_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VW-1:0]    a_new_vel_x_o,
  output logic signed [VW-1:0]    a_new_vel_y_o,
  output logic signed [VW-1:0]    b_new_vel_x_o,
  output logic signed [VW-1:0]    b_new_vel_y_o,
  output logic                    a_changed_o,
  output logic                    b_changed_o,
  output logic                    degenerate_o
);

  localparam int unsigned NSTG  = 6 + QW;    // valid stages before the output register
  localparam int unsigned SIDEN = NSTG - 2;  // sideband stages from the third stage on

  logic                 pipe_en;
  logic [NSTG-1:0]      vld_q;
  logic [MSW-1:0]       static_mass_q;
  logic                 out_valid_q;

  // The pipeline advances when the output register is empty or being drained.
  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  // Static mass register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      static_mass_q <= '0;
    end else if (cfg_we_i) begin
      static_mass_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q       <= {vld_q[NSTG-2:0], in_valid_i};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  // Stage 1: differences in sign and magnitude, static tests, mass sum.
  logic signed [DIFW-1:0] drx, dry, dvx, dvy;
  logic [DIFW-1:0]        ndrx, ndry, ndvx, ndvy;
  s1_t                    s1_d, s1_q;

  always_comb begin
    drx  = $signed({b_pos_x_i[VW-1], b_pos_x_i}) - $signed({a_pos_x_i[VW-1], a_pos_x_i});
    dry  = $signed({b_pos_y_i[VW-1], b_pos_y_i}) - $signed({a_pos_y_i[VW-1], a_pos_y_i});
    dvx  = $signed({b_vel_x_i[VW-1], b_vel_x_i}) - $signed({a_vel_x_i[VW-1], a_vel_x_i});
    dvy  = $signed({b_vel_y_i[VW-1], b_vel_y_i}) - $signed({a_vel_y_i[VW-1], a_vel_y_i});
    ndrx = -drx;
    ndry = -dry;
    ndvx = -dvx;
    ndvy = -dvy;
    s1_d.drx_neg = drx[DIFW-1];
    s1_d.dry_neg = dry[DIFW-1];
    s1_d.dvx_neg = dvx[DIFW-1];
    s1_d.dvy_neg = dvy[DIFW-1];
    s1_d.drxm    = drx[DIFW-1] ? ndrx[MAGW-1:0] : drx[MAGW-1:0];
    s1_d.drym    = dry[DIFW-1] ? ndry[MAGW-1:0] : dry[MAGW-1:0];
    s1_d.dvxm    = dvx[DIFW-1] ? ndvx[MAGW-1:0] : dvx[MAGW-1:0];
    s1_d.dvym    = dvy[DIFW-1] ? ndvy[MAGW-1:0] : dvy[MAGW-1:0];
    s1_d.am      = a_mass_i;
    s1_d.bm      = b_mass_i;
    s1_d.sum     = {1'b0, a_mass_i} + {1'b0, b_mass_i};
    s1_d.a_stat  = (a_mass_i == static_mass_q) && (a_vel_x_i == '0) && (a_vel_y_i == '0);
    s1_d.b_stat  = (b_mass_i == static_mass_q) && (b_vel_x_i == '0) && (b_vel_y_i == '0);
    s1_d.avx     = a_vel_x_i;
    s1_d.avy     = a_vel_y_i;
    s1_d.bvx     = b_vel_x_i;
    s1_d.bvy     = b_vel_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: four 32x32 products and the degenerate test.
  s2_t s2_d, s2_q;

  always_comb begin
    s2_d.p1      = PRW'(s1_q.dvxm) * PRW'(s1_q.drxm);
    s2_d.p2      = PRW'(s1_q.dvym) * PRW'(s1_q.drym);
    s2_d.dx2     = PRW'(s1_q.drxm) * PRW'(s1_q.drxm);
    s2_d.dy2     = PRW'(s1_q.drym) * PRW'(s1_q.drym);
    s2_d.s1      = s1_q.dvx_neg ^ s1_q.drx_neg;
    s2_d.s2      = s1_q.dvy_neg ^ s1_q.dry_neg;
    s2_d.drx_neg = s1_q.drx_neg;
    s2_d.dry_neg = s1_q.dry_neg;
    s2_d.drxm    = s1_q.drxm;
    s2_d.drym    = s1_q.drym;
    s2_d.am      = s1_q.am;
    s2_d.bm      = s1_q.bm;
    s2_d.sum     = s1_q.sum;
    s2_d.deg     = ((s1_q.drxm == '0) && (s1_q.drym == '0)) || (s1_q.sum == '0);
    s2_d.a_upd   = !s2_d.deg && !s1_q.a_stat;
    s2_d.b_upd   = !s2_d.deg && !s1_q.b_stat;
    s2_d.avx     = s1_q.avx;
    s2_d.avy     = s1_q.avy;
    s2_d.bvx     = s1_q.bvx;
    s2_d.bvy     = s1_q.bvy;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: squared distance and signed dot product.
  logic [DOTW-1:0] p1e, p2e, dist_d, dot_d;
  logic            ds;
  side_t           side3_d;
  logic [DOTW-1:0] dist_q, dot_q;
  logic [MAGW-1:0] drxm3_q, drym3_q;
  logic [MSW-1:0]  am3_q, bm3_q;
  logic [SUMW-1:0] sum3_q;
  side_t           side_q [SIDEN];

  always_comb begin
    p1e    = {1'b0, s2_q.p1};
    p2e    = {1'b0, s2_q.p2};
    dist_d = {1'b0, s2_q.dx2} + {1'b0, s2_q.dy2};
    if (s2_q.s1 == s2_q.s2) begin
      dot_d = p1e + p2e;
      ds    = s2_q.s1;
    end else if (p1e >= p2e) begin
      dot_d = p1e - p2e;
      ds    = s2_q.s1;
    end else begin
      dot_d = p2e - p1e;
      ds    = s2_q.s2;
    end
    side3_d.avx   = s2_q.avx;
    side3_d.avy   = s2_q.avy;
    side3_d.bvx   = s2_q.bvx;
    side3_d.bvy   = s2_q.bvy;
    side3_d.a_upd = s2_q.a_upd;
    side3_d.b_upd = s2_q.b_upd;
    side3_d.deg   = s2_q.deg;
    side3_d.neg_x = s2_q.drx_neg ^ ds;
    side3_d.neg_y = s2_q.dry_neg ^ ds;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dist_q  <= dist_d;
      dot_q   <= dot_d;
      drxm3_q <= s2_q.drxm;
      drym3_q <= s2_q.drym;
      am3_q   <= s2_q.am;
      bm3_q   <= s2_q.bm;
      sum3_q  <= s2_q.sum;
    end
  end

  // Sideband shift line from stage 3 to the divider's last stage.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= side3_d;
      for (int j = 1; j < SIDEN; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Stage 4: denominator and the two mass-weighted dot products.
  den_t             den4_q;
  logic [BASEW-1:0] ba_q, bb_q;
  logic [MAGW-1:0]  drxm4_q, drym4_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      den4_q  <= DENW'(dist_q) * DENW'(sum3_q);
      ba_q    <= BASEW'(dot_q) * BASEW'(bm3_q);
      bb_q    <= BASEW'(dot_q) * BASEW'(am3_q);
      drxm4_q <= drxm3_q;
      drym4_q <= drym3_q;
    end
  end

  // Stage 5: base times distance component, split into two partial products.
  logic [BASEW-1:0]      base5 [NLANE];
  logic [MAGW-1:0]       dm5   [NLANE];
  logic [LOW+MAGW-1:0]   plo_q [NLANE];
  logic [HIW+MAGW-1:0]   phi_q [NLANE];
  den_t                  den5_q;

  always_comb begin
    base5[LANE_AX] = ba_q;
    base5[LANE_AY] = ba_q;
    base5[LANE_BX] = bb_q;
    base5[LANE_BY] = bb_q;
    dm5[LANE_AX]   = drxm4_q;
    dm5[LANE_AY]   = drym4_q;
    dm5[LANE_BX]   = drxm4_q;
    dm5[LANE_BY]   = drym4_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      den5_q <= den4_q;
      for (int l = 0; l < NLANE; l++) begin
        plo_q[l] <= (LOW+MAGW)'(base5[l][LOW-1:0]) * (LOW+MAGW)'(dm5[l]);
        phi_q[l] <= (HIW+MAGW)'(base5[l][BASEW-1:LOW]) * (HIW+MAGW)'(dm5[l]);
      end
    end
  end

  // Stage 6: join the partial products and apply the factor of two.
  num_t             num_t6 [NLANE];
  num_t [NLANE-1:0] num6_q;
  den_t             den6_q;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      num_t6[l] = NUMW'({phi_q[l], {LOW{1'b0}}}) + NUMW'(plo_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      den6_q <= den5_q;
      for (int l = 0; l < NLANE; l++) begin
        num6_q[l] <= {num_t6[l][NUMW-2:0], 1'b0};
      end
    end
  end

  // Divider: quotients truncated toward zero.
  quo_t [NLANE-1:0] quo;

  edcol_div u_div (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (num6_q),
    .den_i (den6_q),
    .quo_o (quo)
  );

  // Final: signed velocity change, sum and saturation.
  side_t                 sl;
  logic signed [RSW-1:0] cq   [NLANE];
  logic signed [RSW-1:0] chx, chy, bhx, bhy;
  logic signed [VW-1:0]  nax_d, nay_d, nbx_d, nby_d;

  always_comb begin
    sl = side_q[SIDEN-1];
    for (int l = 0; l < NLANE; l++) begin
      cq[l] = $signed({{(RSW-QW){1'b0}}, quo[l]});
    end
    chx   = sl.neg_x ? -cq[LANE_AX] : cq[LANE_AX];
    chy   = sl.neg_y ? -cq[LANE_AY] : cq[LANE_AY];
    bhx   = sl.neg_x ? -cq[LANE_BX] : cq[LANE_BX];
    bhy   = sl.neg_y ? -cq[LANE_BY] : cq[LANE_BY];
    nax_d = sl.a_upd ? sat_vel(RSW'(sl.avx) + chx) : sl.avx;
    nay_d = sl.a_upd ? sat_vel(RSW'(sl.avy) + chy) : sl.avy;
    nbx_d = sl.b_upd ? sat_vel(RSW'(sl.bvx) - bhx) : sl.bvx;
    nby_d = sl.b_upd ? sat_vel(RSW'(sl.bvy) - bhy) : sl.bvy;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (pipe_en && vld_q[NSTG-1]) begin
      a_new_vel_x_o <= nax_d;
      a_new_vel_y_o <= nay_d;
      b_new_vel_x_o <= nbx_d;
      b_new_vel_y_o <= nby_d;
      a_changed_o   <= sl.a_upd;
      b_changed_o   <= sl.b_upd;
      degenerate_o  <= sl.deg;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks on the pipeline control and the result flags.
  `EDC_ASSERT_IMP(a_stall_only_on_output, !in_ready_o, out_valid_o && !out_ready_i, "input blocked without an output stall")
  `EDC_ASSERT_IMP(a_deg_no_update, out_valid_o && degenerate_o, !a_changed_o && !b_changed_o, "degenerate result marked as updated")
  `EDC_ASSERT_NEXT(a_last_reaches_out, vld_q[NSTG-1] && pipe_en, out_valid_o, "finished item lost before the output register")

endmodule
